// File: sv/tkc_pkg.sv
// Shared types and constants for the TTL keyed cache table.
package tkc_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int TIME_W = 48;
    localparam int TTL_W = 32;
    localparam int CAP_W = 7;
    localparam int CFG_W = 32;
    localparam int USED_W = 7;
    localparam int STAT_W = 32;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int WORD_W = TIME_W + VAL_W + KEY_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);
    localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(60000);

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic {
        CFG_CAPACITY = 1'b0,
        CFG_TTL      = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic             load;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             eval;
        logic             commit;
    } tkc_cmd_t;

    typedef struct packed {
        logic out_free;
    } tkc_status_t;

endpackage

// File: sv/tkc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/tkc_datapath.sv
// Datapath of the cache table: entry storage, scan trackers, counters and result word.
module tkc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tkc_pkg::tkc_cmd_t             cmd,
    output tkc_pkg::tkc_status_t          status,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [tkc_pkg::CFG_W-1:0]     cfg_data,
    input  logic [1:0]                    operation,
    input  logic [tkc_pkg::KEY_W-1:0]     lookup_key,
    input  logic [tkc_pkg::VAL_W-1:0]     write_value,
    input  logic [tkc_pkg::TIME_W-1:0]    now_ms,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic                          found,
    output logic [tkc_pkg::VAL_W-1:0]     read_value,
    output logic [tkc_pkg::USED_W-1:0]    entries_used,
    output logic [tkc_pkg::STAT_W-1:0]    hits_seen,
    output logic [tkc_pkg::STAT_W-1:0]    misses_seen
);

    import tkc_pkg::*;

    // Configuration.
    logic [CAP_W-1:0] capacity_reg;
    logic [TTL_W-1:0] ttl_reg;

    // Item held for the duration of its scan.
    op_t               op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [TIME_W-1:0] now_reg;

    // Table state.
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [STAT_W-1:0]  hits_reg, hits_next;
    logic [STAT_W-1:0]  misses_reg, misses_next;

    // Scan pipeline and trackers.
    logic              cmp_en_reg;
    logic [IDX_W-1:0]  cmp_addr_reg;
    logic              match_found_reg;
    logic [IDX_W-1:0]  match_idx_reg;
    logic [VAL_W-1:0]  match_value_reg;
    logic [TIME_W-1:0] match_stamp_reg;
    logic              old_found_reg;
    logic [IDX_W-1:0]  old_idx_reg;
    logic [KEY_W-1:0]  old_key_reg;
    logic [TIME_W-1:0] old_stamp_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;

    // Decision taken after the scan.
    logic             expired_reg;
    logic             evict_reg;
    logic             tgt_ok_reg;
    logic [IDX_W-1:0] tgt_idx_reg;

    // Result word.
    logic              out_valid_reg;
    logic              found_reg;
    logic [VAL_W-1:0]  read_value_reg;
    logic [USED_W-1:0] used_reg;
    logic [STAT_W-1:0] hits_out_reg;
    logic [STAT_W-1:0] misses_out_reg;

    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_we;
    logic [KEY_W-1:0]  rd_key;
    logic [VAL_W-1:0]  rd_value;
    logic [TIME_W-1:0] rd_stamp;
    logic              rd_valid;

    logic              found_next;
    logic [VAL_W-1:0]  read_value_next;
    logic [CAP_W-1:0]  cap_nz;
    logic              evict_cond;
    logic [TIME_W-1:0] age;
    logic              expired_next;
    logic              evict_next;
    logic [IDX_W-1:0]  tgt_idx_next;

    tkc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tgt_idx_reg),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr),
        .rdata (ram_rdata)
    );

    assign ram_wdata = {now_reg, val_reg, key_reg};
    assign rd_key    = ram_rdata[KEY_W-1:0];
    assign rd_value  = ram_rdata[KEY_W +: VAL_W];
    assign rd_stamp  = ram_rdata[KEY_W + VAL_W +: TIME_W];
    assign rd_valid  = valid_reg[cmp_addr_reg];

    assign status.out_free = !out_valid_reg || !out_stall;

    // A capacity of zero acts as one; a full table always evicts on an insert of a new key.
    assign cap_nz     = (capacity_reg == '0) ? CAP_W'(1) : capacity_reg;
    assign evict_cond = (CMP_W'(total_reg) >= CMP_W'(cap_nz)) ||
                        (total_reg == CNT_W'(ENTRIES));

    // A stamp later than the current time counts as age zero.
    assign age          = (now_reg >= match_stamp_reg) ? (now_reg - match_stamp_reg) : '0;
    assign expired_next = age > TIME_W'(ttl_reg);
    assign evict_next   = (op_reg == OP_INSERT) && !match_found_reg && evict_cond &&
                          old_found_reg;

    always_comb
    begin
        if (evict_next && (!free_found_reg || (old_idx_reg < free_idx_reg)))
        begin
            tgt_idx_next = old_idx_reg;
        end
        else
        begin
            tgt_idx_next = free_idx_reg;
        end
    end

    always_comb
    begin
        valid_next      = valid_reg;
        total_next      = total_reg;
        hits_next       = hits_reg;
        misses_next     = misses_reg;
        found_next      = 1'b0;
        read_value_next = '0;
        ram_we          = 1'b0;
        case (op_reg)
            OP_LOOKUP:
            begin
                if (match_found_reg && !expired_reg)
                begin
                    found_next      = 1'b1;
                    read_value_next = match_value_reg;
                    hits_next       = (hits_reg == '1) ? hits_reg : hits_reg + 1'b1;
                end
                else
                begin
                    misses_next = (misses_reg == '1) ? misses_reg : misses_reg + 1'b1;
                    if (match_found_reg)
                    begin
                        valid_next[match_idx_reg] = 1'b0;
                        total_next                = total_reg - 1'b1;
                    end
                end
            end
            OP_INSERT:
            begin
                if (!match_found_reg && tgt_ok_reg)
                begin
                    if (evict_reg)
                    begin
                        valid_next[old_idx_reg] = 1'b0;
                    end
                    else
                    begin
                        total_next = total_reg + 1'b1;
                    end
                    valid_next[tgt_idx_reg] = 1'b1;
                    ram_we                  = cmd.commit;
                end
            end
            OP_CLEAR:
            begin
                valid_next  = '0;
                total_next  = '0;
                hits_next   = '0;
                misses_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg    <= CAP_RESET;
            ttl_reg         <= TTL_RESET;
            op_reg          <= OP_NOP;
            valid_reg       <= '0;
            total_reg       <= '0;
            hits_reg        <= '0;
            misses_reg      <= '0;
            cmp_en_reg      <= 1'b0;
            match_found_reg <= 1'b0;
            old_found_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
            expired_reg     <= 1'b0;
            evict_reg       <= 1'b0;
            tgt_ok_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_CAPACITY: capacity_reg <= cfg_data[CAP_W-1:0];
                    CFG_TTL:      ttl_reg      <= cfg_data[TTL_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            cmp_en_reg <= cmd.rd_en;

            if (cmd.load)
            begin
                op_reg          <= op_t'(operation);
                match_found_reg <= 1'b0;
                old_found_reg   <= 1'b0;
                free_found_reg  <= 1'b0;
            end
            else if (cmp_en_reg)
            begin
                // Keys are unique among valid entries, so the first match is the only one.
                if (rd_valid && (rd_key == key_reg) && !match_found_reg)
                begin
                    match_found_reg <= 1'b1;
                end
                if (rd_valid && (!old_found_reg ||
                    ({rd_stamp, rd_key} < {old_stamp_reg, old_key_reg})))
                begin
                    old_found_reg <= 1'b1;
                end
                if (!rd_valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end

            if (cmd.eval)
            begin
                expired_reg <= match_found_reg && expired_next;
                evict_reg   <= evict_next;
                tgt_ok_reg  <= free_found_reg || evict_next;
            end

            if (cmd.commit)
            begin
                valid_reg     <= valid_next;
                total_reg     <= total_next;
                hits_reg      <= hits_next;
                misses_reg    <= misses_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= lookup_key;
            val_reg <= write_value;
            now_reg <= now_ms;
        end
        cmp_addr_reg <= cmd.rd_addr;
        if (cmp_en_reg && !cmd.load)
        begin
            if (rd_valid && (rd_key == key_reg) && !match_found_reg)
            begin
                match_idx_reg   <= cmp_addr_reg;
                match_value_reg <= rd_value;
                match_stamp_reg <= rd_stamp;
            end
            if (rd_valid && (!old_found_reg ||
                ({rd_stamp, rd_key} < {old_stamp_reg, old_key_reg})))
            begin
                old_idx_reg   <= cmp_addr_reg;
                old_key_reg   <= rd_key;
                old_stamp_reg <= rd_stamp;
            end
            if (!rd_valid && !free_found_reg)
            begin
                free_idx_reg <= cmp_addr_reg;
            end
        end
        if (cmd.eval)
        begin
            tgt_idx_reg <= tgt_idx_next;
        end
        if (cmd.commit)
        begin
            found_reg      <= found_next;
            read_value_reg <= read_value_next;
            used_reg       <= USED_W'(total_next);
            hits_out_reg   <= hits_next;
            misses_out_reg <= misses_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign read_value   = read_value_reg;
    assign entries_used = used_reg;
    assign hits_seen    = hits_out_reg;
    assign misses_seen  = misses_out_reg;

    // A new word must never overwrite one that is still stalled.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || !out_stall))
        else $error("result word overwritten while stalled");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(ENTRIES))
        else $error("occupancy above table size");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed word not presented");

    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> (hits_out_reg != '0))
        else $error("hit reported without a hit count");

endmodule

// File: sv/tkc_ctrl.sv
// Controller state machine that sequences the table scan for each input word.
module tkc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           operation,
    input  tkc_pkg::tkc_status_t status,
    output tkc_pkg::tkc_cmd_t    cmd
);

    import tkc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EVAL,
        S_FINISH
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             accept;
    op_t              op_in;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign op_in    = op_t'(operation);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd.load    = 1'b0;
        cmd.rd_en   = 1'b0;
        cmd.rd_addr = cnt_reg;
        cmd.eval    = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    if ((op_in == OP_LOOKUP) || (op_in == OP_INSERT))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                // The last entry read is compared in this cycle.
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // The scan walks the table one entry per cycle.
    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && cnt_reg != LAST_IDX) |=>
        (state_reg == S_SCAN && cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("scan skipped an entry");

    a_commit_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (state_reg == S_IDLE))
        else $error("commit did not return to idle");

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_SCAN || state_reg == S_FINISH))
        else $error("accepted word did not start processing");

endmodule

// File: sv/ttl_keyed_cache_table.sv
// A lookup or insert word scans all entries, compares the last read, is evaluated, then commits.
// Clear and no-op words give their result 1 cycle after acceptance.
// A new word is taken only after the last one commits, and commit waits for a free output;
// the scan reads one table entry per cycle through the single RAM read port.
// Reset clears all valid bits, occupancy and both counters at once; capacity resets to 64
// and time-to-live to 60000. Entry contents are left as they are.
module ttl_keyed_cache_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [tkc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    operation,
    input  logic [tkc_pkg::KEY_W-1:0]     lookup_key,
    input  logic [tkc_pkg::VAL_W-1:0]     write_value,
    input  logic [tkc_pkg::TIME_W-1:0]    now_ms,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          found,
    output logic [tkc_pkg::VAL_W-1:0]     read_value,
    output logic [tkc_pkg::USED_W-1:0]    entries_used,
    output logic [tkc_pkg::STAT_W-1:0]    hits_seen,
    output logic [tkc_pkg::STAT_W-1:0]    misses_seen
);

    import tkc_pkg::*;

    tkc_cmd_t    cmd;
    tkc_status_t status;

    tkc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .status    (status),
        .cmd       (cmd)
    );

    tkc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .operation    (operation),
        .lookup_key   (lookup_key),
        .write_value  (write_value),
        .now_ms       (now_ms),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .found        (found),
        .read_value   (read_value),
        .entries_used (entries_used),
        .hits_seen    (hits_seen),
        .misses_seen  (misses_seen)
    );

endmodule
